>>> src/dmac_pkg.sv
// dmac_pkg: widths, reset values, register indexes and result codes
// shared by the moving average crossover block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dmac_pkg;

    localparam int PRICE_W     = 32;
    localparam int PERIOD_W    = 9;
    localparam int EVENT_W     = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int DIV_BITS    = 2;

    localparam logic [PERIOD_W-1:0] SHORT_PERIOD_RST = 9'd50;
    localparam logic [PERIOD_W-1:0] LONG_PERIOD_RST  = 9'd200;

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PERIOD  = 1'd1;

    localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
    localparam logic [EVENT_W-1:0] EV_DEATH  = 2'd1;
    localparam logic [EVENT_W-1:0] EV_GOLDEN = 2'd2;

    typedef enum logic [1:0] {
        REL_NONE  = 2'd0,
        REL_ABOVE = 2'd1,
        REL_BELOW = 2'd2,
        REL_EQUAL = 2'd3
    } rel_t;

endpackage

`default_nettype wire

>>> src/dmac_ring.sv
// dmac_ring: sample ring memory, one write port and one registered read port
// depends on dmac_pkg for the sample width
`timescale 1ns / 1ps
`default_nettype none

module dmac_ring #(
    parameter int DEPTH = 256
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic [dmac_pkg::PRICE_W-1:0] wr_data,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic [dmac_pkg::PRICE_W-1:0] rd_data
);
    import dmac_pkg::*;

    logic [PRICE_W-1:0] mem [DEPTH];
    logic [PRICE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> src/dmac_div.sv
// dmac_div: iterative unsigned divider, two quotient bits per cycle
// depends on dmac_pkg; quotient must fit the sample width
`timescale 1ns / 1ps
`default_nettype none

module dmac_div #(
    parameter int DIVIDEND_W = 41
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [DIVIDEND_W-1:0]         dividend,
    input  logic [dmac_pkg::PERIOD_W-1:0] divisor,
    output logic                          done,
    output logic [dmac_pkg::PRICE_W-1:0]  quotient
);
    import dmac_pkg::*;

    localparam int QUO_W   = PRICE_W;
    localparam int STEPS   = QUO_W / DIV_BITS;
    localparam int COUNT_W = $clog2(STEPS);

    logic                busy_reg;
    logic                done_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [PERIOD_W-1:0] rem_reg;
    logic [QUO_W-1:0]    quo_reg;
    logic [PERIOD_W-1:0] divisor_reg;
    logic [PERIOD_W-1:0] rem_next;
    logic [QUO_W-1:0]    quo_next;

    always_comb
    begin
        logic [PERIOD_W:0] trial;
        logic              qbit;
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial = {rem_next, quo_next[QUO_W-1]};
            if (trial >= {1'b0, divisor_reg})
            begin
                rem_next = PERIOD_W'(trial - {1'b0, divisor_reg});
                qbit     = 1'b1;
            end
            else
            begin
                rem_next = trial[PERIOD_W-1:0];
                qbit     = 1'b0;
            end
            quo_next = {quo_next[QUO_W-2:0], qbit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (count_reg == COUNT_W'(STEPS - 1));
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + COUNT_W'(1);
                if (count_reg == COUNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // high part of the dividend is below the divisor, so it seeds the remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= PERIOD_W'(dividend >> QUO_W);
            quo_reg     <= dividend[QUO_W-1:0];
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> src/dual_moving_average_crossover.sv
// dual_moving_average_crossover: top level, sequencer, window sums and cross compare
// depends on dmac_pkg, dmac_ring and dmac_div
// per item: read both window tails, write the sample and update the sums; once the
//   averages are ready, two multiplies, a compare and two divider runs at two bits
//   per cycle; one item at a time; a stalled result holds the block through the stall
// reset: periods 50 and 200, stream empty, no clearing pass; ring contents undefined
`timescale 1ns / 1ps
`default_nettype none

module dual_moving_average_crossover #(
    parameter int MAX_PERIOD = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dmac_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dmac_pkg::PERIOD_W-1:0]  cfg_data,
    input  logic                           price_valid,
    output logic                           price_stall,
    input  logic [dmac_pkg::PRICE_W-1:0]   close_price,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic                           averages_ready,
    output logic [dmac_pkg::PRICE_W-1:0]   short_average,
    output logic [dmac_pkg::PRICE_W-1:0]   long_average,
    output logic [dmac_pkg::EVENT_W-1:0]   cross_event
);
    import dmac_pkg::*;

    localparam int PTR_W     = $clog2(MAX_PERIOD);
    localparam int SEEN_W    = $clog2(MAX_PERIOD + 1);
    localparam int PMAX_EFF  = (MAX_PERIOD < 511) ? MAX_PERIOD : 511;
    localparam int SUM_W     = PRICE_W + $clog2(PMAX_EFF + 1);
    localparam int PROD_W    = SUM_W + PERIOD_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_SHORT,
        S_RD_LONG,
        S_WRITE,
        S_MUL_L,
        S_MUL_R,
        S_CMP,
        S_DIV_S,
        S_DIV_L,
        S_DONE
    } state_t;

    function automatic logic [PERIOD_W-1:0] eff_period(input logic [PERIOD_W-1:0] p);
        if (p == '0)
            return PERIOD_W'(1);
        else if (32'(p) > 32'(MAX_PERIOD))
            return PERIOD_W'(MAX_PERIOD);
        else
            return p;
    endfunction

    function automatic logic [PTR_W-1:0] back_idx(input logic [PTR_W-1:0] wp,
                                                  input logic [PERIOD_W-1:0] p);
        if (32'(wp) >= 32'(p))
            return PTR_W'(32'(wp) - 32'(p));
        else
            return PTR_W'(32'(wp) + 32'(MAX_PERIOD) - 32'(p));
    endfunction

    state_t              state_reg;
    logic [PERIOD_W-1:0] short_period_reg;
    logic [PERIOD_W-1:0] long_period_reg;
    logic [PTR_W-1:0]    wp_reg;
    logic [SEEN_W-1:0]   seen_reg;
    logic [SUM_W-1:0]    short_sum_reg;
    logic [SUM_W-1:0]    long_sum_reg;
    rel_t                prev_rel_reg;
    logic                div_start_reg;
    logic                result_valid_reg;

    logic [PRICE_W-1:0]  price_reg;
    logic [PROD_W-1:0]   lhs_reg;
    logic [PROD_W-1:0]   rhs_reg;
    logic                ready_reg;
    logic [PRICE_W-1:0]  avg_s_reg;
    logic [PRICE_W-1:0]  avg_l_reg;
    logic [EVENT_W-1:0]  ev_reg;
    logic                out_ready_reg;
    logic [PRICE_W-1:0]  out_short_reg;
    logic [PRICE_W-1:0]  out_long_reg;
    logic [EVENT_W-1:0]  out_event_reg;

    logic [PERIOD_W-1:0] ps;
    logic [PERIOD_W-1:0] pl;
    logic [PERIOD_W-1:0] pmax;
    logic                gate_s;
    logic                gate_l;
    logic [SEEN_W-1:0]   seen_inc;
    logic                ready_now;
    logic [PTR_W-1:0]    rd_addr;
    logic [PRICE_W-1:0]  rd_data;
    logic                ring_wr_en;
    logic [SUM_W-1:0]    mul_a;
    logic [PERIOD_W-1:0] mul_b;
    logic [PROD_W-1:0]   mul_prod;
    rel_t                rel;
    logic [SUM_W-1:0]    div_dividend;
    logic [PERIOD_W-1:0] div_divisor;
    logic                div_done;
    logic [PRICE_W-1:0]  div_quotient;
    logic                price_take;
    logic                cfg_take;
    logic                load_out;

    assign ps   = eff_period(short_period_reg);
    assign pl   = eff_period(long_period_reg);
    assign pmax = (ps > pl) ? ps : pl;

    assign gate_s    = 32'(seen_reg) >= 32'(ps);
    assign gate_l    = 32'(seen_reg) >= 32'(pl);
    assign seen_inc  = (32'(seen_reg) < 32'(MAX_PERIOD)) ? seen_reg + SEEN_W'(1) : seen_reg;
    assign ready_now = 32'(seen_inc) >= 32'(pmax);

    assign cfg_ready   = (state_reg == S_IDLE);
    assign price_stall = (state_reg != S_IDLE) || cfg_valid;
    assign cfg_take    = cfg_valid && cfg_ready;
    assign price_take  = price_valid && !price_stall;
    assign load_out    = (state_reg == S_DONE) && (!result_valid_reg || !result_stall);

    assign rd_addr    = (state_reg == S_RD_SHORT) ? back_idx(wp_reg, ps) : back_idx(wp_reg, pl);
    assign ring_wr_en = (state_reg == S_WRITE);

    assign mul_a    = (state_reg == S_MUL_L) ? short_sum_reg : long_sum_reg;
    assign mul_b    = (state_reg == S_MUL_L) ? pl : ps;
    assign mul_prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_comb
    begin
        if (lhs_reg > rhs_reg)
            rel = REL_ABOVE;
        else if (lhs_reg < rhs_reg)
            rel = REL_BELOW;
        else
            rel = REL_EQUAL;
    end

    assign div_dividend = (state_reg == S_DIV_S) ? short_sum_reg : long_sum_reg;
    assign div_divisor  = (state_reg == S_DIV_S) ? ps : pl;

    dmac_ring #(
        .DEPTH (MAX_PERIOD)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_wr_en),
        .wr_addr (wp_reg),
        .wr_data (price_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dmac_div #(
        .DIVIDEND_W (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            short_period_reg <= SHORT_PERIOD_RST;
            long_period_reg  <= LONG_PERIOD_RST;
            wp_reg           <= '0;
            seen_reg         <= '0;
            short_sum_reg    <= '0;
            long_sum_reg     <= '0;
            prev_rel_reg     <= REL_NONE;
            div_start_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= (state_reg == S_CMP) || ((state_reg == S_DIV_S) && div_done);
            if (load_out)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_take)
                    begin
                        unique case (cfg_index)
                            REG_SHORT_PERIOD: short_period_reg <= cfg_data;
                            REG_LONG_PERIOD:  long_period_reg  <= cfg_data;
                            default: ;
                        endcase
                        // restart the stream so windows never mix periods
                        wp_reg        <= '0;
                        seen_reg      <= '0;
                        short_sum_reg <= '0;
                        long_sum_reg  <= '0;
                        prev_rel_reg  <= REL_NONE;
                    end
                    else if (price_take)
                    begin
                        state_reg <= S_RD_SHORT;
                    end
                end
                S_RD_SHORT:
                begin
                    state_reg <= S_RD_LONG;
                end
                S_RD_LONG:
                begin
                    if (gate_s)
                    begin
                        short_sum_reg <= short_sum_reg - SUM_W'(rd_data);
                    end
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    short_sum_reg <= short_sum_reg + SUM_W'(price_reg);
                    if (gate_l)
                        long_sum_reg <= long_sum_reg - SUM_W'(rd_data) + SUM_W'(price_reg);
                    else
                        long_sum_reg <= long_sum_reg + SUM_W'(price_reg);
                    if (wp_reg == PTR_W'(MAX_PERIOD - 1))
                        wp_reg <= '0;
                    else
                        wp_reg <= wp_reg + PTR_W'(1);
                    seen_reg  <= seen_inc;
                    state_reg <= ready_now ? S_MUL_L : S_DONE;
                end
                S_MUL_L:
                begin
                    state_reg <= S_MUL_R;
                end
                S_MUL_R:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    prev_rel_reg <= rel;
                    state_reg    <= S_DIV_S;
                end
                S_DIV_S:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_DIV_L;
                    end
                end
                S_DIV_L:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (load_out)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (price_take)
        begin
            price_reg <= close_price;
        end
        if (state_reg == S_MUL_L)
        begin
            lhs_reg <= mul_prod;
        end
        if (state_reg == S_MUL_R)
        begin
            rhs_reg <= mul_prod;
        end
        if (state_reg == S_WRITE)
        begin
            ready_reg <= ready_now;
            if (!ready_now)
            begin
                avg_s_reg <= '0;
                avg_l_reg <= '0;
                ev_reg    <= EV_NONE;
            end
        end
        if (state_reg == S_CMP)
        begin
            if (prev_rel_reg == REL_ABOVE && rel == REL_BELOW)
                ev_reg <= EV_DEATH;
            else if (prev_rel_reg == REL_BELOW && rel == REL_ABOVE)
                ev_reg <= EV_GOLDEN;
            else
                ev_reg <= EV_NONE;
        end
        if (state_reg == S_DIV_S && div_done)
        begin
            avg_s_reg <= div_quotient;
        end
        if (state_reg == S_DIV_L && div_done)
        begin
            avg_l_reg <= div_quotient;
        end
        if (load_out)
        begin
            out_ready_reg <= ready_reg;
            out_short_reg <= avg_s_reg;
            out_long_reg  <= avg_l_reg;
            out_event_reg <= ev_reg;
        end
    end

    assign result_valid   = result_valid_reg;
    assign averages_ready = out_ready_reg;
    assign short_average  = out_short_reg;
    assign long_average   = out_long_reg;
    assign cross_event    = out_event_reg;

endmodule

`default_nettype wire

>>> tb/dual_moving_average_crossover_tb.sv
// testbench for dual_moving_average_crossover: closing prices in, averages and cross flags out,
// each result checked against a window-sum tracker kept inside the bench
// depends on dmac_pkg and the dual_moving_average_crossover rtl
`timescale 1ns / 1ps

module dual_moving_average_crossover_tb;
    import dmac_pkg::*;

    localparam int RING_DEPTH   = 256;
    localparam int ITEM_TARGET  = 1150;
    localparam int HOLD_AT      = 900;
    localparam int STALL_HOLD   = 600;
    localparam int DRAIN_CYCLES = 48;
    localparam int IDLE_LIMIT   = 20000;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic                ready;
        logic [PRICE_W-1:0]  short_avg;
        logic [PRICE_W-1:0]  long_avg;
        logic [EVENT_W-1:0]  cross_ev;
    } sma_result_t;

    class sma_cross_tracker;
        logic [PRICE_W-1:0]  ring [RING_DEPTH];
        int unsigned         wr_ptr;
        int unsigned         seen;
        logic [63:0]         short_sum;
        logic [63:0]         long_sum;
        rel_t                last_rel;
        logic [PERIOD_W-1:0] short_reg;
        logic [PERIOD_W-1:0] long_reg;
        sma_result_t         awaited [$];
        int unsigned         errors;

        function new();
            short_reg = SHORT_PERIOD_RST;
            long_reg  = LONG_PERIOD_RST;
            errors    = 0;
            restart();
        endfunction

        function void restart();
            wr_ptr    = 0;
            seen      = 0;
            short_sum = '0;
            long_sum  = '0;
            last_rel  = REL_NONE;
        endfunction

        function int unsigned clamp_period(logic [PERIOD_W-1:0] p);
            if (p == 0)
                return 1;
            if (p > RING_DEPTH)
                return RING_DEPTH;
            return 32'(p);
        endfunction

        function void write_period(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] val);
            if (idx == REG_SHORT_PERIOD)
                short_reg = val;
            else
                long_reg = val;
            restart();
        endfunction

        function void take_price(logic [PRICE_W-1:0] price);
            int unsigned ps;
            int unsigned pl;
            int unsigned pmax;
            int unsigned wp;
            logic [63:0] lhs;
            logic [63:0] rhs;
            rel_t        rel;
            sma_result_t r;
            ps   = clamp_period(short_reg);
            pl   = clamp_period(long_reg);
            pmax = (ps > pl) ? ps : pl;
            wp   = wr_ptr;
            // retire samples leaving each window before the slot is reused
            if (seen >= ps)
                short_sum = short_sum - ring[(wp + RING_DEPTH - ps) % RING_DEPTH];
            if (seen >= pl)
                long_sum = long_sum - ring[(wp + RING_DEPTH - pl) % RING_DEPTH];
            short_sum = short_sum + price;
            long_sum  = long_sum + price;
            ring[wp]  = price;
            wr_ptr    = (wp + 1) % RING_DEPTH;
            if (seen < RING_DEPTH)
                seen++;
            r = '0;
            if (seen >= pmax)
            begin
                lhs = short_sum * 64'(pl);
                rhs = long_sum * 64'(ps);
                rel = (lhs > rhs) ? REL_ABOVE : ((lhs < rhs) ? REL_BELOW : REL_EQUAL);
                r.ready     = 1'b1;
                r.short_avg = 32'(short_sum / 64'(ps));
                r.long_avg  = 32'(long_sum / 64'(pl));
                if (last_rel == REL_ABOVE && rel == REL_BELOW)
                    r.cross_ev = EV_DEATH;
                else if (last_rel == REL_BELOW && rel == REL_ABOVE)
                    r.cross_ev = EV_GOLDEN;
                else
                    r.cross_ev = EV_NONE;
                last_rel = rel;
            end
            awaited = {awaited, r};
        endfunction

        function void match_result(sma_result_t got);
            sma_result_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected result: ready %0d short %0d long %0d cross %0d",
                             got.ready, got.short_avg, got.long_avg, got.cross_ev);
                return;
            end
            want = awaited.pop_front();
            if (got.ready !== want.ready || got.short_avg !== want.short_avg ||
                got.long_avg !== want.long_avg || got.cross_ev !== want.cross_ev)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("mismatch exp/got: ready %0d/%0d short %0d/%0d %s",
                             want.ready, got.ready, want.short_avg, got.short_avg,
                             $sformatf("long %0d/%0d cross %0d/%0d",
                                       want.long_avg, got.long_avg,
                                       want.cross_ev, got.cross_ev));
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PERIOD_W-1:0]  cfg_data;
    logic                 price_valid;
    logic                 price_stall;
    logic [PRICE_W-1:0]   close_price;
    logic                 result_valid;
    logic                 result_stall;
    logic                 averages_ready;
    logic [PRICE_W-1:0]   short_average;
    logic [PRICE_W-1:0]   long_average;
    logic [EVENT_W-1:0]   cross_event;

    sma_cross_tracker     tracker = new();
    int unsigned          prices_taken = 0;
    int unsigned          idle_cycles = 0;
    logic [PRICE_W-1:0]   walk_level;
    int                   trend = 20;

    // equal start, then swings that give both crossings, then full-scale prices
    logic [PRICE_W-1:0]   cross_script [16] = '{
        32'd10, 32'd10, 32'd10, 32'd20, 32'd0, 32'd0, 32'd40, 32'd0,
        32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0,
        32'h8000_0000, 32'd1
    };

    dual_moving_average_crossover #(
        .MAX_PERIOD(RING_DEPTH)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .price_valid    (price_valid),
        .price_stall    (price_stall),
        .close_price    (close_price),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .averages_ready (averages_ready),
        .short_average  (short_average),
        .long_average   (long_average),
        .cross_event    (cross_event)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin : result_monitor
        sma_result_t got;
        if (rst_n && result_valid && !result_stall)
        begin
            got.ready     = averages_ready;
            got.short_avg = short_average;
            got.long_avg  = long_average;
            got.cross_ev  = cross_event;
            tracker.match_result(got);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((price_valid && !price_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("dual_moving_average_crossover_tb: errors");
                $finish;
            end
        end
    end

    initial
    begin : result_sink
        bit          held;
        int unsigned recv_pct;
        held = 1'b0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            // long hold-off so the block backs up into its input
            if (!held && prices_taken >= HOLD_AT)
            begin
                held = 1'b1;
                result_stall <= 1'b1;
                repeat (STALL_HOLD) @(posedge clk);
            end
            recv_pct = (prices_taken < ITEM_TARGET / 3) ? 76 :
                       (prices_taken < 2 * ITEM_TARGET / 3) ? 9 : 0;
            result_stall <= ($urandom_range(0, 99) < recv_pct);
        end
    end

    function automatic logic [PRICE_W-1:0] market_price();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            trend = (trend > 0) ? -int'($urandom_range(5, 60)) : int'($urandom_range(5, 60));
        if (pick < 8)
            return ($urandom_range(0, 1) != 0) ? '1 : '0;
        if (pick < 20)
            return $urandom;
        walk_level = walk_level + trend + int'($urandom_range(0, 64)) - 32;
        return walk_level;
    endfunction

    task automatic send_price(input logic [PRICE_W-1:0] price);
        int unsigned send_pct;
        send_pct = (prices_taken < ITEM_TARGET / 3) ? 9 :
                   (prices_taken < 2 * ITEM_TARGET / 3) ? 76 : 0;
        while ($urandom_range(0, 99) < send_pct)
        begin
            price_valid <= 1'b0;
            @(posedge clk);
        end
        price_valid <= 1'b1;
        close_price <= price;
        do
            @(posedge clk);
        while (price_stall);
        tracker.take_price(price);
        prices_taken++;
    endtask

    task automatic write_period(input logic [CFG_IDX_W-1:0] idx,
                                input logic [PERIOD_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.write_period(idx, val);
    endtask

    task automatic drain_results();
        price_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_periods(input bit do_short, input bit do_long,
                               input logic [PERIOD_W-1:0] s_len,
                               input logic [PERIOD_W-1:0] l_len);
        drain_results();
        if (do_short)
            write_period(REG_SHORT_PERIOD, s_len);
        if (do_long)
            write_period(REG_LONG_PERIOD, l_len);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int unsigned mode;
        int unsigned s_len;
        int unsigned l_len;
        int unsigned ps;
        int unsigned pl;
        int unsigned n_items;
        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= REG_SHORT_PERIOD;
        cfg_data    <= '0;
        price_valid <= 1'b0;
        close_price <= '0;
        walk_level  = $urandom;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset periods: nothing ready yet
        send_price('0);
        send_price('1);
        send_price(32'h5555_5555);
        send_price(32'hAAAA_AAAA);
        send_price(32'd1);

        set_periods(1'b1, 1'b1, 9'd2, 9'd3);
        foreach (cross_script[i])
            send_price(cross_script[i]);

        // zero periods act as one
        set_periods(1'b1, 1'b1, 9'd0, 9'd0);
        repeat (30) send_price(market_price());

        // oversize short period clamps, long at the maximum
        set_periods(1'b1, 1'b1, 9'd511, 9'd256);
        repeat (RING_DEPTH + 40) send_price(market_price());

        while (prices_taken < ITEM_TARGET)
        begin
            mode  = $urandom_range(0, 3);
            s_len = $urandom_range(1, 24);
            l_len = $urandom_range(1, 40);
            set_periods(mode != 2, mode != 1, PERIOD_W'(s_len), PERIOD_W'(l_len));
            ps = tracker.clamp_period(tracker.short_reg);
            pl = tracker.clamp_period(tracker.long_reg);
            n_items = ((ps > pl) ? ps : pl) + $urandom_range(20, 80);
            repeat (n_items) send_price(market_price());
        end

        drain_results();
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("dual_moving_average_crossover_tb: clean");
        else
            $display("dual_moving_average_crossover_tb: errors");
        $finish;
    end

endmodule
